// ===== design/tga_stream_decoder_top_macros.svh =====
// Assertion macros used by the stream decoder top level.
`ifndef TGA_STREAM_DECODER_TOP_MACROS_SVH
`define TGA_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, ignored during reset.
`define TGA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, ignored during reset.
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tga_pkg.sv =====
// Types and constants of the TGA stream decoder.
`default_nettype none

package tga_pkg;

    // parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_PACKET = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CMAP  = 2'd1;
    localparam logic [1:0] ERR_TYPE  = 2'd2;
    localparam logic [1:0] ERR_DEPTH = 2'd3;

    // header byte offsets
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;

    localparam logic [7:0] CMAP_PRESENT = 8'd1;
    localparam logic [7:0] IMG_RGB_RAW  = 8'd2;
    localparam logic [7:0] IMG_GRAY_RAW = 8'd3;
    localparam logic [7:0] IMG_RGB_RLE  = 8'd10;
    localparam logic [7:0] IMG_GRAY_RLE = 8'd11;
    localparam logic [7:0] DEPTH_8      = 8'd8;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;

    localparam logic [7:0] PKT_LEN_MASK = 8'h7F;
    localparam logic [7:0] PKT_RUN_BIT  = 8'h80;
    localparam logic [7:0] DESC_TOP_BIT = 8'h20;
    localparam logic [7:0] DESC_RTL_BIT = 8'h10;

    typedef struct packed {
        logic [2:0]  phase;
        logic [4:0]  header_position;
        logic [7:0]  id_bytes_left;
        logic        rle_mode;
        logic [2:0]  pixel_bytes;
        logic [15:0] width_value;
        logic [15:0] height_value;
        logic [1:0]  descriptor_flags;
        logic [31:0] pixels_left;
        logic [7:0]  packet_left;
        logic        packet_is_run;
        logic [1:0]  byte_in_pixel;
        logic [31:0] pixel_gather;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        last_of_image;
        logic [1:0]  error_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  bytes_per_pixel;
        logic        bottom_up_rows;
        logic        right_to_left;
    } result_t;

endpackage

`default_nettype wire

// ===== design/tga_stream_if.sv =====
// Valid/ready channel interfaces for the byte input and the decoded results.
`default_nettype none

interface tga_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tga_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        last_of_image;
    logic [1:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  bytes_per_pixel;
    logic        bottom_up_rows;
    logic        right_to_left;

    modport source (
        output valid, input ready,
        output result_kind, output pixel_value, output repeat_count,
        output last_of_image, output error_code, output image_width,
        output image_height, output bytes_per_pixel, output bottom_up_rows,
        output right_to_left
    );
    modport sink (
        input valid, output ready,
        input result_kind, input pixel_value, input repeat_count,
        input last_of_image, input error_code, input image_width,
        input image_height, input bytes_per_pixel, input bottom_up_rows,
        input right_to_left
    );
endinterface

`default_nettype wire

// ===== design/tga_step.sv =====
// Next-state and result logic for one file byte.
`default_nettype none

module tga_step (
    input  tga_pkg::parse_state_t st,
    input  logic [7:0]            data_byte,
    input  logic                  start_of_file,
    output tga_pkg::parse_state_t nxt,
    output logic                  res_valid,
    output tga_pkg::result_t      res
);
    import tga_pkg::*;

    function automatic logic [2:0] pick_phase(input logic [31:0] left,
                                              input logic rle,
                                              input logic [7:0] pkt);
        logic [2:0] ph;
        if (left == 32'd0)
            ph = PH_DONE;
        else if (rle && pkt == 8'd0)
            ph = PH_PACKET;
        else
            ph = PH_PIXEL;
        return ph;
    endfunction

    parse_state_t cur;
    logic [31:0]  gather;
    logic [31:0]  pix;
    logic [7:0]   cnt;
    logic [31:0]  left_after;
    logic [31:0]  area;

    assign cur  = start_of_file ? parse_state_t'('0) : st;
    assign area = 32'(cur.width_value) * 32'(cur.height_value);

    always_comb
    begin
        gather = cur.pixel_gather;
        case (cur.byte_in_pixel)
            2'd0:    gather[7:0]   = gather[7:0]   | data_byte;
            2'd1:    gather[15:8]  = gather[15:8]  | data_byte;
            2'd2:    gather[23:16] = gather[23:16] | data_byte;
            default: gather[31:24] = gather[31:24] | data_byte;
        endcase

        // red and blue trade places for colour pixels
        if (cur.pixel_bytes >= 3'd3)
            pix = {gather[31:24], gather[7:0], gather[15:8], gather[23:16]};
        else
            pix = gather;

        if (cur.rle_mode && cur.packet_is_run)
            cnt = (32'(cur.packet_left) > cur.pixels_left) ? cur.pixels_left[7:0]
                                                           : cur.packet_left;
        else
            cnt = 8'd1;
        left_after = cur.pixels_left - 32'(cnt);
    end

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '0;

        case (cur.phase)
            PH_HEADER:
            begin
                nxt.header_position = cur.header_position + 5'd1;
                case (cur.header_position)
                    HDR_ID_LEN:    nxt.id_bytes_left = data_byte;
                    HDR_CMAP_TYPE:
                    begin
                        if (data_byte == CMAP_PRESENT)
                        begin
                            res_valid      = 1'b1;
                            res.result_kind = KIND_ERROR;
                            res.error_code = ERR_CMAP;
                            nxt.phase      = PH_ERROR;
                        end
                    end
                    HDR_IMG_TYPE:
                    begin
                        if (data_byte inside {IMG_RGB_RAW, IMG_GRAY_RAW})
                            nxt.rle_mode = 1'b0;
                        else if (data_byte inside {IMG_RGB_RLE, IMG_GRAY_RLE})
                            nxt.rle_mode = 1'b1;
                        else
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_TYPE;
                            nxt.phase       = PH_ERROR;
                        end
                    end
                    HDR_WIDTH_LO:  nxt.width_value  = {8'd0, data_byte};
                    HDR_WIDTH_HI:  nxt.width_value  = {data_byte, cur.width_value[7:0]};
                    HDR_HEIGHT_LO: nxt.height_value = {8'd0, data_byte};
                    HDR_HEIGHT_HI: nxt.height_value = {data_byte, cur.height_value[7:0]};
                    HDR_DEPTH:
                    begin
                        if (data_byte == DEPTH_8)
                            nxt.pixel_bytes = 3'd1;
                        else if (data_byte == DEPTH_24)
                            nxt.pixel_bytes = 3'd3;
                        else if (data_byte == DEPTH_32)
                            nxt.pixel_bytes = 3'd4;
                        else
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_ERROR;
                            res.error_code  = ERR_DEPTH;
                            nxt.phase       = PH_ERROR;
                        end
                    end
                    HDR_DESC:
                    begin
                        nxt.descriptor_flags = {(data_byte & DESC_TOP_BIT) == 8'd0,
                                                (data_byte & DESC_RTL_BIT) != 8'd0};
                        nxt.pixels_left   = area;
                        nxt.packet_left   = 8'd0;
                        nxt.byte_in_pixel = 2'd0;
                        nxt.pixel_gather  = 32'd0;
                        res_valid           = 1'b1;
                        res.result_kind     = KIND_HEADER;
                        res.last_of_image   = (area == 32'd0);
                        res.image_width     = cur.width_value;
                        res.image_height    = cur.height_value;
                        res.bytes_per_pixel = cur.pixel_bytes;
                        res.bottom_up_rows  = nxt.descriptor_flags[1];
                        res.right_to_left   = nxt.descriptor_flags[0];
                        if (area != 32'd0 && cur.id_bytes_left != 8'd0)
                            nxt.phase = PH_ID;
                        else
                            nxt.phase = pick_phase(area, cur.rle_mode, 8'd0);
                    end
                    default: ;
                endcase
            end

            PH_ID:
            begin
                if (cur.id_bytes_left != 8'd0)
                    nxt.id_bytes_left = cur.id_bytes_left - 8'd1;
                if (nxt.id_bytes_left == 8'd0)
                    nxt.phase = pick_phase(cur.pixels_left, cur.rle_mode, cur.packet_left);
            end

            PH_PACKET:
            begin
                nxt.packet_left   = (data_byte & PKT_LEN_MASK) + 8'd1;
                nxt.packet_is_run = (data_byte & PKT_RUN_BIT) != 8'd0;
                nxt.byte_in_pixel = 2'd0;
                nxt.pixel_gather  = 32'd0;
                nxt.phase         = PH_PIXEL;
            end

            PH_PIXEL:
            begin
                if ({1'b0, cur.byte_in_pixel} + 3'd1 < cur.pixel_bytes)
                begin
                    nxt.pixel_gather  = gather;
                    nxt.byte_in_pixel = cur.byte_in_pixel + 2'd1;
                end
                else
                begin
                    if (cur.rle_mode && cur.packet_is_run)
                        nxt.packet_left = 8'd0;
                    else if (cur.rle_mode && cur.packet_left != 8'd0)
                        nxt.packet_left = cur.packet_left - 8'd1;
                    nxt.pixels_left   = left_after;
                    nxt.byte_in_pixel = 2'd0;
                    nxt.pixel_gather  = 32'd0;
                    nxt.phase         = pick_phase(left_after, cur.rle_mode, nxt.packet_left);
                    res_valid         = 1'b1;
                    res.result_kind   = KIND_PIXEL;
                    res.pixel_value   = pix;
                    res.repeat_count  = cnt;
                    res.last_of_image = (left_after == 32'd0);
                end
            end

            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tga_stream_decoder_top.sv =====
// Top level of the TGA stream decoder: beat registers around the byte parser.
// Path: a byte's beat is taken into the input register, parsed, and its result loaded into the result register.
// Throughput: one byte per cycle, held back only while a result waits unread.
// A single combinational parse step lies between the input register and the result register.
// Reset (rst_n low, asynchronous) restarts parsing at header byte 0 and drops
// any byte or result held in the beat registers.
`default_nettype none
`include "tga_stream_decoder_top_macros.svh"

module tga_stream_decoder_top (
    input logic       clk,
    input logic       rst_n,
    tga_in_if.sink    file_data,
    tga_out_if.source decoded
);
    import tga_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_sof_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_reg;
    result_t      step_res;
    logic         step_valid;
    logic         advance;

    tga_step u_step (
        .st            (st_reg),
        .data_byte     (in_byte_reg),
        .start_of_file (in_sof_reg),
        .nxt           (st_next),
        .res_valid     (step_valid),
        .res           (step_res)
    );

    // a byte with no result never waits for the output slot
    assign advance = in_valid_reg && (!out_valid_reg || decoded.ready || !step_valid);
    assign file_data.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance && step_valid)
            out_valid_next = 1'b1;
        else if (decoded.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                st_reg <= st_next;
            if (file_data.ready)
                in_valid_reg <= file_data.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (file_data.ready && file_data.valid)
        begin
            in_byte_reg <= file_data.data_byte;
            in_sof_reg  <= file_data.start_of_file;
        end
        if (advance && step_valid)
            out_reg <= step_res;
    end

    assign decoded.valid           = out_valid_reg;
    assign decoded.result_kind     = out_reg.result_kind;
    assign decoded.pixel_value     = out_reg.pixel_value;
    assign decoded.repeat_count    = out_reg.repeat_count;
    assign decoded.last_of_image   = out_reg.last_of_image;
    assign decoded.error_code      = out_reg.error_code;
    assign decoded.image_width     = out_reg.image_width;
    assign decoded.image_height    = out_reg.image_height;
    assign decoded.bytes_per_pixel = out_reg.bytes_per_pixel;
    assign decoded.bottom_up_rows  = out_reg.bottom_up_rows;
    assign decoded.right_to_left   = out_reg.right_to_left;

    `TGA_ASSERT_NEXT(a_result_loaded, advance && step_valid, out_valid_reg, "result beat lost")
    `TGA_ASSERT_NOW(a_pixels_pending, (st_reg.phase == PH_PIXEL || st_reg.phase == PH_PACKET), st_reg.pixels_left != 32'd0, "pixel phase with no pixels left")
    `TGA_ASSERT_NOW(a_gather_bound, st_reg.phase == PH_PIXEL, {1'b0, st_reg.byte_in_pixel} < st_reg.pixel_bytes, "byte index beyond pixel size")
    `TGA_ASSERT_NOW(a_run_count, out_valid_reg && out_reg.result_kind == KIND_PIXEL, out_reg.repeat_count != 8'd0 && out_reg.repeat_count <= 8'd128, "run count out of range")
    `TGA_ASSERT_NOW(a_error_coded, out_valid_reg && out_reg.result_kind == KIND_ERROR, out_reg.error_code != ERR_NONE, "error result without a code")

endmodule

`default_nettype wire

// ===== sim/tb_tga_stream_decoder_top.sv =====
// Self-checking testbench for the TGA stream decoder: directed table, then random files.
`timescale 1ns / 100ps

module tb_tga_stream_decoder_top;
    import tga_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_BYTES = 1750;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 26;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_check_t;
    typedef enum logic [1:0] {SHAPE_GOOD, SHAPE_CMAP, SHAPE_TYPE, SHAPE_DEPTH} file_shape_t;

    typedef struct {
        logic [7:0] data;
        logic       sof;
        row_check_t check;
        result_t    want;
    } beat_row_t;

    logic clk;
    logic rst_n;

    tga_in_if  byte_ch ();
    tga_out_if decoded_ch ();

    tga_stream_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .file_data (byte_ch),
        .decoded   (decoded_ch)
    );

    result_t     expected_decodes [$];
    beat_row_t   directed_rows [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned byte_count  = 0;
    int unsigned idle_pct    = IDLE_PCT;

    // decoder state as the predictor sees it
    logic [2:0]  stage;
    logic [4:0]  hdr_idx;
    logic [7:0]  id_skip;
    logic        rle_on;
    logic [2:0]  px_size;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        rows_bottom_up;
    logic        rows_right_left;
    logic [31:0] px_remaining;
    logic [7:0]  pkt_remaining;
    logic        pkt_run;
    logic [1:0]  gather_idx;
    logic [31:0] gather_word;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        decoded_ch.ready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
    end

    function automatic void clear_decoder();
        stage           = PH_HEADER;
        hdr_idx         = '0;
        id_skip         = '0;
        rle_on          = 1'b0;
        px_size         = '0;
        img_w           = '0;
        img_h           = '0;
        rows_bottom_up  = 1'b0;
        rows_right_left = 1'b0;
        px_remaining    = '0;
        pkt_remaining   = '0;
        pkt_run         = 1'b0;
        gather_idx      = '0;
        gather_word     = '0;
    endfunction

    function automatic void choose_data_stage();
        if (px_remaining == 0)
            stage = PH_DONE;
        else if (rle_on && pkt_remaining == 0)
            stage = PH_PACKET;
        else
            stage = PH_PIXEL;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic sof,
                                        output bit emitted, output result_t res);
        logic [4:0]  pos;
        logic [1:0]  fault;
        logic [31:0] word;
        logic [31:0] cnt;

        res     = '0;
        emitted = 1'b0;
        fault   = ERR_NONE;
        if (sof)
            clear_decoder();
        case (stage)
            PH_HEADER:
            begin
                pos     = hdr_idx;
                hdr_idx = hdr_idx + 5'd1;
                case (pos)
                    HDR_ID_LEN:    id_skip = b;
                    HDR_CMAP_TYPE: if (b == CMAP_PRESENT) fault = ERR_CMAP;
                    HDR_IMG_TYPE:
                    begin
                        if (b == IMG_RGB_RAW || b == IMG_GRAY_RAW)
                            rle_on = 1'b0;
                        else if (b == IMG_RGB_RLE || b == IMG_GRAY_RLE)
                            rle_on = 1'b1;
                        else
                            fault = ERR_TYPE;
                    end
                    HDR_WIDTH_LO:  img_w = {8'h00, b};
                    HDR_WIDTH_HI:  img_w = img_w | {b, 8'h00};
                    HDR_HEIGHT_LO: img_h = {8'h00, b};
                    HDR_HEIGHT_HI: img_h = img_h | {b, 8'h00};
                    HDR_DEPTH:
                    begin
                        if (b == DEPTH_8)
                            px_size = 3'd1;
                        else if (b == DEPTH_24)
                            px_size = 3'd3;
                        else if (b == DEPTH_32)
                            px_size = 3'd4;
                        else
                            fault = ERR_DEPTH;
                    end
                    HDR_DESC:
                    begin
                        rows_bottom_up      = (b & DESC_TOP_BIT) == 0;
                        rows_right_left     = (b & DESC_RTL_BIT) != 0;
                        px_remaining        = 32'(img_w) * 32'(img_h);
                        pkt_remaining       = '0;
                        gather_idx          = '0;
                        gather_word         = '0;
                        res.result_kind     = KIND_HEADER;
                        res.last_of_image   = px_remaining == 0;
                        res.image_width     = img_w;
                        res.image_height    = img_h;
                        res.bytes_per_pixel = px_size;
                        res.bottom_up_rows  = rows_bottom_up;
                        res.right_to_left   = rows_right_left;
                        emitted             = 1'b1;
                        if (px_remaining != 0 && id_skip != 0)
                            stage = PH_ID;
                        else
                            choose_data_stage();
                    end
                    default: ;
                endcase
                if (fault != ERR_NONE)
                begin
                    res.result_kind = KIND_ERROR;
                    res.error_code  = fault;
                    stage           = PH_ERROR;
                    emitted         = 1'b1;
                end
            end
            PH_ID:
            begin
                if (id_skip != 0)
                    id_skip = id_skip - 8'd1;
                if (id_skip == 0)
                    choose_data_stage();
            end
            PH_PACKET:
            begin
                pkt_remaining = (b & PKT_LEN_MASK) + 8'd1;
                pkt_run       = (b & PKT_RUN_BIT) != 0;
                gather_idx    = '0;
                gather_word   = '0;
                stage         = PH_PIXEL;
            end
            PH_PIXEL:
            begin
                gather_word = gather_word | (32'(b) << {gather_idx, 3'b000});
                if (32'(gather_idx) + 1 < 32'(px_size))
                    gather_idx = gather_idx + 2'd1;
                else
                begin
                    word = gather_word;
                    // red and blue trade places for colour pixels
                    if (px_size >= 3)
                        word = {word[31:24], word[7:0], word[15:8], word[23:16]};
                    if (rle_on && pkt_run)
                    begin
                        cnt = 32'(pkt_remaining);
                        if (cnt > px_remaining)
                            cnt = px_remaining;
                        pkt_remaining = '0;
                    end
                    else
                    begin
                        cnt = 32'd1;
                        if (rle_on && pkt_remaining != 0)
                            pkt_remaining = pkt_remaining - 8'd1;
                    end
                    px_remaining      = px_remaining - cnt;
                    gather_idx        = '0;
                    gather_word       = '0;
                    res.result_kind   = KIND_PIXEL;
                    res.pixel_value   = word;
                    res.repeat_count  = cnt[7:0];
                    res.last_of_image = px_remaining == 0;
                    emitted           = 1'b1;
                    choose_data_stage();
                end
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // one input beat: random hold-off, then hold valid until it is taken
    task automatic send_byte(input logic [7:0] data, input logic sof,
                             output bit emitted, output result_t res);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= data;
        byte_ch.start_of_file <= sof;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        decode_byte(data, sof, emitted, res);
    endtask

    task automatic feed(input logic [7:0] data, input logic sof, input bit live);
        bit      emitted;
        result_t res;

        send_byte(data, sof, emitted, res);
        if (emitted)
            expected_decodes.push_back(res);
        if (live)
            byte_count++;
    endtask

    function automatic void add_row(input logic [7:0] data, input logic sof,
                                    input row_check_t check, input result_t want);
        directed_rows.push_back('{data, sof, check, want});
    endfunction

    function automatic result_t error_result(input logic [1:0] code);
        result_t r;

        r             = '0;
        r.result_kind = KIND_ERROR;
        r.error_code  = code;
        return r;
    endfunction

    // one file: mostly well formed, some with header faults or cut short
    task automatic send_file();
        file_shape_t shape;
        logic [7:0]  hdr [18];
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] px_total;
        int unsigned pick;
        int unsigned bpp;
        int unsigned id_len;
        int unsigned hdr_len;
        int unsigned last_live;
        int unsigned stop_px;
        int unsigned sent_px;
        int unsigned rem;
        int unsigned run_len;
        int unsigned n;
        bit          rle;
        bit          run;
        bit          cut;

        pick = $urandom_range(0, 99);
        if (pick < 7)
            shape = SHAPE_CMAP;
        else if (pick < 13)
            shape = SHAPE_TYPE;
        else if (pick < 19)
            shape = SHAPE_DEPTH;
        else
            shape = SHAPE_GOOD;

        rle = $urandom_range(0, 1);
        if ($urandom_range(0, 1))
            hdr[2] = rle ? IMG_RGB_RLE : IMG_RGB_RAW;
        else
            hdr[2] = rle ? IMG_GRAY_RLE : IMG_GRAY_RAW;
        case ($urandom_range(0, 2))
            0:
            begin
                hdr[16] = DEPTH_8;
                bpp     = 1;
            end
            1:
            begin
                hdr[16] = DEPTH_24;
                bpp     = 3;
            end
            default:
            begin
                hdr[16] = DEPTH_32;
                bpp     = 4;
            end
        endcase

        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            w = 16'hFFFF;
            h = 16'hFFFF;
        end
        else if (pick < 7)
        begin
            w = 16'd0;
            h = 16'($urandom);
        end
        else if (pick < 10)
        begin
            w = 16'($urandom);
            h = 16'd0;
        end
        else if (pick < 16)
        begin
            w = 16'($urandom_range(1, 64));
            h = 16'd1;
        end
        else
        begin
            w = 16'($urandom_range(1, 6));
            h = 16'($urandom_range(1, 5));
        end

        if ($urandom_range(0, 59) == 0)
            id_len = 255;
        else
            id_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;

        hdr[0] = 8'(id_len);
        hdr[1] = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(2, 255));
        for (n = 3; n < 12; n++)
            hdr[n] = 8'($urandom);
        hdr[12] = w[7:0];
        hdr[13] = w[15:8];
        hdr[14] = h[7:0];
        hdr[15] = h[15:8];
        hdr[17] = 8'($urandom);

        // bytes after a header fault are dead and not counted
        last_live = 17;
        case (shape)
            SHAPE_CMAP:
            begin
                hdr[1]    = CMAP_PRESENT;
                last_live = 1;
            end
            SHAPE_TYPE:
            begin
                do
                    hdr[2] = 8'($urandom);
                while (hdr[2] == IMG_RGB_RAW || hdr[2] == IMG_GRAY_RAW ||
                       hdr[2] == IMG_RGB_RLE || hdr[2] == IMG_GRAY_RLE);
                last_live = 2;
            end
            SHAPE_DEPTH:
            begin
                do
                    hdr[16] = 8'($urandom);
                while (hdr[16] == DEPTH_8 || hdr[16] == DEPTH_24 || hdr[16] == DEPTH_32);
                last_live = 16;
            end
            default: ;
        endcase

        hdr_len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 17) : 18;
        for (n = 0; n < hdr_len; n++)
            feed(hdr[n], n == 0, n <= last_live);
        if (shape != SHAPE_GOOD || hdr_len < 18)
            return;

        px_total = 32'(w) * 32'(h);
        if (px_total == 0)
        begin
            repeat ($urandom_range(0, 2))
                feed(8'($urandom), 1'b0, 1'b0);
            return;
        end

        for (n = 0; n < id_len; n++)
            feed(8'($urandom), 1'b0, 1'b1);

        // large images are always cut short by the next file
        cut = (px_total > 64) || ($urandom_range(0, 99) < 8);
        if (cut)
            stop_px = $urandom_range(0, (px_total > 40) ? 40 : px_total);
        else
            stop_px = px_total;

        sent_px = 0;
        while (sent_px < stop_px)
        begin
            if (!rle)
            begin
                repeat (bpp)
                    feed(8'($urandom), 1'b0, 1'b1);
                sent_px++;
            end
            else
            begin
                rem  = stop_px - sent_px;
                pick = $urandom_range(0, 99);
                run  = $urandom_range(0, 1);
                if (pick < 75)
                    run_len = $urandom_range(1, 4);
                else if (pick < 92)
                    run_len = $urandom_range(1, (rem + 2 > 128) ? 128 : rem + 2);
                else
                begin
                    run_len = 128;
                    run     = 1'b1;
                end
                feed({run, 7'(run_len - 1)}, 1'b0, 1'b1);
                repeat (run ? bpp : run_len * bpp)
                    feed(8'($urandom), 1'b0, 1'b1);
                sent_px += run_len;
            end
        end

        if (cut)
        begin
            repeat ($urandom_range(0, bpp - 1))
                feed(8'($urandom), 1'b0, 1'b1);
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
                feed(8'($urandom), 1'b0, 1'b0);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t seen;
        result_t want;

        if (rst_n && decoded_ch.valid && decoded_ch.ready)
        begin
            seen.result_kind     = decoded_ch.result_kind;
            seen.pixel_value     = decoded_ch.pixel_value;
            seen.repeat_count    = decoded_ch.repeat_count;
            seen.last_of_image   = decoded_ch.last_of_image;
            seen.error_code      = decoded_ch.error_code;
            seen.image_width     = decoded_ch.image_width;
            seen.image_height    = decoded_ch.image_height;
            seen.bytes_per_pixel = decoded_ch.bytes_per_pixel;
            seen.bottom_up_rows  = decoded_ch.bottom_up_rows;
            seen.right_to_left   = decoded_ch.right_to_left;
            if (expected_decodes.size() == 0)
                flag_mismatch($sformatf("unexpected result, kind %0h", seen.result_kind));
            else
            begin
                want = expected_decodes.pop_front();
                if (seen.result_kind !== want.result_kind)
                    flag_mismatch($sformatf("result_kind %0h, want %0h",
                                            seen.result_kind, want.result_kind));
                if (seen.pixel_value !== want.pixel_value)
                    flag_mismatch($sformatf("pixel_value %0h, want %0h",
                                            seen.pixel_value, want.pixel_value));
                if (seen.repeat_count !== want.repeat_count)
                    flag_mismatch($sformatf("repeat_count %0d, want %0d",
                                            seen.repeat_count, want.repeat_count));
                if (seen.last_of_image !== want.last_of_image)
                    flag_mismatch($sformatf("last_of_image %0b, want %0b",
                                            seen.last_of_image, want.last_of_image));
                if (seen.error_code !== want.error_code)
                    flag_mismatch($sformatf("error_code %0d, want %0d",
                                            seen.error_code, want.error_code));
                if (seen.image_width !== want.image_width)
                    flag_mismatch($sformatf("image_width %0h, want %0h",
                                            seen.image_width, want.image_width));
                if (seen.image_height !== want.image_height)
                    flag_mismatch($sformatf("image_height %0h, want %0h",
                                            seen.image_height, want.image_height));
                if (seen.bytes_per_pixel !== want.bytes_per_pixel)
                    flag_mismatch($sformatf("bytes_per_pixel %0d, want %0d",
                                            seen.bytes_per_pixel, want.bytes_per_pixel));
                if (seen.bottom_up_rows !== want.bottom_up_rows)
                    flag_mismatch($sformatf("bottom_up_rows %0b, want %0b",
                                            seen.bottom_up_rows, want.bottom_up_rows));
                if (seen.right_to_left !== want.right_to_left)
                    flag_mismatch($sformatf("right_to_left %0b, want %0b",
                                            seen.right_to_left, want.right_to_left));
            end
        end
    end

    initial
    begin : stimulus
        result_t     none_res;
        result_t     empty_hdr;
        result_t     res;
        bit          emitted;
        int unsigned i;

        rst_n                 = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = 8'h00;
        byte_ch.start_of_file = 1'b0;
        decoded_ch.ready      = 1'b0;
        clear_decoder();

        none_res                  = '0;
        empty_hdr                 = '0;
        empty_hdr.result_kind     = KIND_HEADER;
        empty_hdr.last_of_image   = 1'b1;
        empty_hdr.image_width     = 16'h0000;
        empty_hdr.image_height    = 16'hFFFF;
        empty_hdr.bytes_per_pixel = 3'd4;
        empty_hdr.bottom_up_rows  = 1'b0;
        empty_hdr.right_to_left   = 1'b1;

        // straight out of reset, no start marker: colour map fault, then a dead beat
        add_row(8'h00, 1'b0, ROW_SILENT, none_res);
        add_row(CMAP_PRESENT, 1'b0, ROW_TYPED, error_result(ERR_CMAP));
        add_row(8'hFF, 1'b0, ROW_SILENT, none_res);
        // bad image type
        add_row(8'hFF, 1'b1, ROW_SILENT, none_res);
        add_row(8'h00, 1'b0, ROW_SILENT, none_res);
        add_row(8'h07, 1'b0, ROW_TYPED, error_result(ERR_TYPE));
        // gray RLE at 32 bits, zero width: empty image, trailing beat ignored
        add_row(8'h00, 1'b1, ROW_SILENT, none_res);
        add_row(8'h00, 1'b0, ROW_SILENT, none_res);
        add_row(IMG_GRAY_RLE, 1'b0, ROW_SILENT, none_res);
        for (i = 3; i < 12; i++)
            add_row(8'(i * 29), 1'b0, ROW_PREDICT, none_res);
        add_row(8'h00, 1'b0, ROW_SILENT, none_res);
        add_row(8'h00, 1'b0, ROW_SILENT, none_res);
        add_row(8'hFF, 1'b0, ROW_SILENT, none_res);
        add_row(8'hFF, 1'b0, ROW_SILENT, none_res);
        add_row(DEPTH_32, 1'b0, ROW_SILENT, none_res);
        add_row(8'h30, 1'b0, ROW_TYPED, empty_hdr);
        add_row(8'hAB, 1'b0, ROW_SILENT, none_res);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            send_byte(directed_rows[k].data, directed_rows[k].sof, emitted, res);
            case (directed_rows[k].check)
                ROW_TYPED:   expected_decodes.push_back(directed_rows[k].want);
                ROW_PREDICT: if (emitted) expected_decodes.push_back(res);
                default: ;
            endcase
        end

        while (byte_count < RANDOM_BYTES)
        begin
            // a stretch with both sides flat out
            idle_pct = (byte_count >= 700 && byte_count < 1000) ? 0 : IDLE_PCT;
            send_file();
        end
        idle_pct = IDLE_PCT;

        byte_ch.valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
